### hdl/brxp_pkg.sv
// Shared types and constants for the bitmap RAM plot port.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package brxp_pkg;

    // Store geometry.
    localparam int STORE_BYTES = 32768;
    localparam int PAGE_BYTES  = 16384;
    localparam int LINE_PIXELS = 512;

    localparam int ADDR_W    = $clog2(STORE_BYTES);
    localparam int PAGE_W    = $clog2(PAGE_BYTES);
    // Linear pixel index bits that survive the byte index wrap.
    localparam int PIX_LIN_W = ADDR_W + 3;

    // Control byte bit positions.
    localparam int CTRL_LATCH_OFF = 0;
    localparam int CTRL_ACC_PAGE  = 1;
    localparam int CTRL_INVERT    = 2;
    localparam int CTRL_DISP_PAGE = 4;

    // Item kinds; codes 6 and 7 do nothing.
    typedef enum logic [2:0] {
        KIND_RAM_RD  = 3'd0,
        KIND_RAM_WR  = 3'd1,
        KIND_CTRL_WR = 3'd2,
        KIND_RB_RD   = 3'd3,
        KIND_SEL_WR  = 3'd4,
        KIND_FETCH   = 3'd5
    } t_kind;

    // Datapath operations issued by the controller each cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_READ_RD,
        OP_READ_DONE,
        OP_WRITE,
        OP_FLIP_RD,
        OP_FLIP_WR,
        OP_CTRL_WR,
        OP_SEL_WR,
        OP_READBACK,
        OP_FETCH_RD,
        OP_FETCH_DONE
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_FLIP
    } t_state;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic invert;
    } t_dp_stat;

endpackage

### hdl/brxp_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brxp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: write, or read into the output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/brxp_dp.sv
// Datapath: video store, control byte, selector, readback latch, result word.
// Depends on brxp_pkg and brxp_ram.
`timescale 1ns / 1ps

module brxp_dp import brxp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_stat      o_stat,
    input  logic          i_cfg_wr,
    input  logic          i_cfg_data,
    input  logic [14:0]   i_ram_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [8:0]    i_pixel_x,
    input  logic [8:0]    i_pixel_y,
    output logic [7:0]    o_rd_data,
    output logic          o_pixel_bit
);

    logic [7:0]        r_ctrl_byte;
    logic [2:0]        r_sel;
    logic [7:0]        r_latch;
    logic              r_paged;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_addr;
    logic [2:0]        r_bit_idx;
    logic [7:0]        r_rd_data;
    logic              r_pixel_bit;

    logic [ADDR_W-1:0]    ctl_addr;
    logic [ADDR_W-1:0]    disp_addr;
    logic [PIX_LIN_W-1:0] pix_lin;
    logic [ADDR_W-1:0]    disp_off;
    logic                 ram_en;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [7:0]           ram_wdata;
    logic [7:0]           ram_rdata;
    logic [7:0]           flip_mask;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[i];
        end
        return r;
    endfunction

    // Page mapping of an offset: wrap to the page, then add the selected page.
    function automatic logic [ADDR_W-1:0] page_map(
        input logic [ADDR_W-1:0] off,
        input logic              paged,
        input logic              page
    );
        logic [ADDR_W-1:0] a;
        if (paged) begin
            a = ADDR_W'(off[PAGE_W-1:0]) | (page ? ADDR_W'(PAGE_BYTES) : '0);
        end else begin
            a = off;
        end
        return a;
    endfunction

    // Controller and display addresses.
    always_comb begin
        pix_lin   = PIX_LIN_W'(i_pixel_y) * PIX_LIN_W'(LINE_PIXELS) + PIX_LIN_W'(i_pixel_x);
        disp_off  = pix_lin[PIX_LIN_W-1:3];
        ctl_addr  = page_map(i_ram_addr, r_paged, r_ctrl_byte[CTRL_ACC_PAGE]);
        disp_addr = page_map(disp_off, r_paged, r_ctrl_byte[CTRL_DISP_PAGE]);
        flip_mask = '0;
        flip_mask[~r_sel] = 1'b1;
    end

    // RAM port control per operation.
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = ctl_addr;
        ram_wdata = i_wr_data;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
            end
            OP_READ_RD, OP_FLIP_RD: begin
                ram_en = 1'b1;
            end
            OP_WRITE: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
            end
            OP_FETCH_RD: begin
                ram_en   = 1'b1;
                ram_addr = disp_addr;
            end
            OP_FLIP_WR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_addr;
                ram_wdata = ram_rdata ^ flip_mask;
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    brxp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_byte <= '0;
            r_sel       <= '0;
            r_latch     <= '0;
            r_paged     <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_paged <= i_cfg_data;
            end
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.op == OP_CTRL_WR) begin
                r_ctrl_byte <= i_wr_data;
            end
            if (i_cmd.op == OP_SEL_WR) begin
                r_sel <= i_wr_data[2:0];
            end
            if (i_cmd.op == OP_READ_DONE && !r_ctrl_byte[CTRL_LATCH_OFF]) begin
                r_latch <= ram_rdata;
            end
        end
    end

    // Access context and result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FLIP_RD) begin
            r_addr <= ctl_addr;
        end
        if (i_cmd.op == OP_FETCH_RD) begin
            r_bit_idx <= i_pixel_x[2:0];
        end
        if (i_cmd.op == OP_READBACK) begin
            r_rd_data   <= reverse8(r_latch);
            r_pixel_bit <= 1'b0;
        end else if (i_cmd.op == OP_READ_DONE) begin
            r_rd_data   <= ram_rdata;
            r_pixel_bit <= 1'b0;
        end else if (i_cmd.op == OP_FETCH_DONE) begin
            r_rd_data   <= '0;
            r_pixel_bit <= ram_rdata[~r_bit_idx];
        end
    end

    assign o_stat.clr_last = (r_clr_addr == '1);
    assign o_stat.invert   = r_ctrl_byte[CTRL_INVERT];
    assign o_rd_data       = r_rd_data;
    assign o_pixel_bit     = r_pixel_bit;

endmodule

### hdl/brxp_ctrl.sv
// Controller: sequences the clearing pass, RAM reads and flip write-backs,
// and owns the result word's valid flag. Depends on brxp_pkg.
`timescale 1ns / 1ps

module brxp_ctrl import brxp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  logic [2:0] i_kind,
    output logic     o_valid,
    input  logic     i_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_ready;
    logic   accept;
    t_kind  kind;

    assign kind     = t_kind'(i_kind);
    // A new word is taken only when the result slot will be free.
    assign in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign accept   = i_valid && in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        KIND_RAM_RD: n_state = ST_READ;
                        KIND_FETCH:  n_state = ST_FETCH;
                        KIND_RAM_WR: n_state = i_stat.invert ? ST_FLIP : ST_IDLE;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath command.
    always_comb begin
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_CLEAR: o_cmd.op = OP_CLEAR;
            ST_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        KIND_RAM_RD:  o_cmd.op = OP_READ_RD;
                        KIND_RAM_WR:  o_cmd.op = i_stat.invert ? OP_FLIP_RD : OP_WRITE;
                        KIND_CTRL_WR: o_cmd.op = OP_CTRL_WR;
                        KIND_RB_RD:   o_cmd.op = OP_READBACK;
                        KIND_SEL_WR:  o_cmd.op = OP_SEL_WR;
                        KIND_FETCH:   o_cmd.op = OP_FETCH_RD;
                        default:      o_cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_READ:  o_cmd.op = OP_READ_DONE;
            ST_FETCH: o_cmd.op = OP_FETCH_DONE;
            ST_FLIP:  o_cmd.op = OP_FLIP_WR;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    // Result slot: loading wins over the consumer taking the old word.
    always_comb begin
        priority if (r_state == ST_READ || r_state == ST_FETCH ||
                     (accept && kind == KIND_RB_RD)) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = in_ready;
    assign o_valid = r_out_valid;

endmodule

### hdl/bitmap_ram_xor_plot_port.sv
// Top level of the bitmap RAM plot port: controller plus datapath.
// Depends on brxp_pkg, brxp_ctrl, brxp_dp and brxp_ram.
`timescale 1ns / 1ps

// One-bit-per-pixel video store of 32768 bytes on a single-port RAM, shared by
// a graphics controller (byte read, byte write or pixel flip, control byte,
// pixel selector, bit-reversed readback) and a display fetch that returns one
// pixel. After reset the block runs a clearing pass over all 32768 bytes, one
// byte per cycle, and takes no word on the input channel until it ends; the
// config write port is open throughout. Control, selector, byte write and
// readback words are done in ST_IDLE. A RAM read, a display fetch and a write
// in invert mode also pass through ST_READ, ST_FETCH or ST_FLIP, because each
// needs the RAM's registered read before the result or the write-back can use
// the single RAM port. A result waits in an output register; while it waits no
// word of any kind is taken, but one can enter in the cycle the result leaves.
module bitmap_ram_xor_plot_port import brxp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [14:0] i_ram_addr,
    input  logic [7:0]  i_wr_data,
    input  logic [8:0]  i_pixel_x,
    input  logic [8:0]  i_pixel_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_rd_data,
    output logic        o_pixel_bit
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    brxp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_kind  (i_kind),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    brxp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_ram_addr  (i_ram_addr),
        .i_wr_data   (i_wr_data),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .o_rd_data   (o_rd_data),
        .o_pixel_bit (o_pixel_bit)
    );

    // No word is taken while the store is being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_CLEAR) |-> !o_ready)
        else $error("word accepted during clearing pass");

    // A RAM read completes in the cycle after it is taken.
    a_read_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == KIND_RAM_RD) |=> (w_cmd.op == OP_READ_DONE))
        else $error("RAM read did not complete");

    // Completing a read or fetch presents a result.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_READ_DONE || w_cmd.op == OP_FETCH_DONE) |=> o_valid)
        else $error("result not presented");

    // A flip write-back always follows its own read.
    a_flip_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_FLIP_WR) |-> $past(w_cmd.op == OP_FLIP_RD))
        else $error("flip write-back without read");

endmodule
